// ===== rtl/tpgt_pkg.sv =====
// types, codes and constants for the touch point gesture tracker
// no dependencies; imported by touch_point_gesture_tracker_core
package tpgt_pkg;

	localparam int COORD_W    = 12;
	localparam int DELTA_W    = 13;
	localparam int SUM_W      = 16;
	localparam int MOTION_W   = 17;
	localparam int TICK_W     = 16;
	localparam int SIZE_W     = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_H     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_V     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LP_TICKS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LP_MOTION  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_MOTION = 3'd7;

	// raw event codes from the controller
	localparam logic [1:0] EV_PRESS   = 2'd0;
	localparam logic [1:0] EV_LIFT    = 2'd1;
	localparam logic [1:0] EV_CONTACT = 2'd2;
	localparam logic [1:0] EV_NONE    = 2'd3;

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_PRESS   = 2'd1,
		KIND_LIFT    = 2'd2,
		KIND_CONTACT = 2'd3
	} kind_t;

	// reset values; width and height are stored as size minus one
	localparam logic [COORD_W-1:0] RST_WIDTH_M1  = 12'd799;
	localparam logic [COORD_W-1:0] RST_HEIGHT_M1 = 12'd479;
	localparam logic [TICK_W-1:0]  RST_LP_TICKS  = 16'd50;
	localparam logic [SUM_W-1:0]   RST_LP_MOTION = 16'd20;
	localparam logic [SUM_W-1:0]   RST_TAP_MOTION = 16'd5;

	localparam logic [SIZE_W-1:0]  SIZE_MAX = 13'd4096;
	localparam logic [TICK_W-1:0]  TICK_MAX = 16'hFFFF;
	localparam logic [SUM_W-1:0]   SUM_POS_MAX = 16'h7FFF;
	localparam logic [SUM_W-1:0]   SUM_NEG_MAX = 16'h8000;

	// screen size to last pixel index, size 0 acts as 1, above 4096 as 4096
	function automatic logic [COORD_W-1:0] size_m1(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] t;
		t = s - 13'd1;
		if (s == '0)
			return '0;
		else if (s > SIZE_MAX)
			return '1;
		else
			return t[COORD_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] abs16(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] n;
		n = -v;
		return v[SUM_W-1] ? n : v;
	endfunction

endpackage

// ===== rtl/touch_point_gesture_tracker_core.sv =====
// touch point gesture tracker: coordinate transform, event decode and per-point
// motion, hold and tap tracking; depends on tpgt_pkg
//
// an accepted record waits in the input register, then goes to the result register
// when that is empty or m_tready is high; per-point state is written at that edge
// throughput: one record per cycle while m_tready is high
// reset: arst_n clears handshake state, all per-point state and loads the
// register defaults (swap on, vertical flip on, 800x480, 50/20/5)
module touch_point_gesture_tracker_core #(
	parameter int TOUCH_POINTS = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// event_x_high, x_low, id_y_high, y_low
	input  logic [tpgt_pkg::IN_DATA_W-1:0]     s_tdata,
	// point_index
	input  logic [tpgt_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pos_x, pos_y, step_dx, step_dy, long_press, tap, zero pad
	output logic [tpgt_pkg::OUT_DATA_W-1:0]    m_tdata,
	// point_tag, event_kind
	output logic [tpgt_pkg::OUT_USER_W-1:0]    m_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tpgt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tpgt_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tpgt_pkg::*;

	localparam int PW = (TOUCH_POINTS > 1) ? $clog2(TOUCH_POINTS) : 1;
	localparam int PAD_W = OUT_DATA_W - (2 * COORD_W + 2 * DELTA_W + 2);

	// configuration
	logic               swap_q, flip_h_q, flip_v_q;
	logic [COORD_W-1:0] w_m1_q, h_m1_q;
	logic [TICK_W-1:0]  lp_ticks_q;
	logic [SUM_W-1:0]   lp_motion_q, tap_motion_q;

	// input stage
	logic               valid_s1;
	logic               idx_s1;
	logic [7:0]         ev_s1, xl_s1, idy_s1, yl_s1;

	// per-point state
	logic [COORD_W-1:0] last_x_q  [TOUCH_POINTS];
	logic [COORD_W-1:0] last_y_q  [TOUCH_POINTS];
	logic [DELTA_W-1:0] last_dx_q [TOUCH_POINTS];
	logic [DELTA_W-1:0] last_dy_q [TOUCH_POINTS];
	logic [SUM_W-1:0]   sum_dx_q  [TOUCH_POINTS];
	logic [SUM_W-1:0]   sum_dy_q  [TOUCH_POINTS];
	logic [TICK_W-1:0]  hold_q    [TOUCH_POINTS];
	logic               mark_q    [TOUCH_POINTS];

	// result register
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [OUT_USER_W-1:0] m_user_q;

	logic               s_accept, adv;
	logic [PW-1:0]      p;
	logic [COORD_W-1:0] rx, ry, x_sw, y_sw, x_cl, y_cl, x_n, y_n;
	kind_t              kind;
	logic [DELTA_W-1:0] dx_n, dy_n;
	logic [SUM_W-1:0]   sdx_n, sdy_n;
	logic [MOTION_W-1:0] sdx_ext, sdy_ext;
	logic [TICK_W-1:0]  hold_n, hold_inc;
	logic               mark_n;
	logic [MOTION_W-1:0] motion_n;
	logic               tap_n;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign s_accept  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q       <= 1'b1;
			flip_h_q     <= 1'b0;
			flip_v_q     <= 1'b1;
			w_m1_q       <= RST_WIDTH_M1;
			h_m1_q       <= RST_HEIGHT_M1;
			lp_ticks_q   <= RST_LP_TICKS;
			lp_motion_q  <= RST_LP_MOTION;
			tap_motion_q <= RST_TAP_MOTION;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SWAP_AXES:  swap_q       <= cfg_data[0];
				REG_FLIP_H:     flip_h_q     <= cfg_data[0];
				REG_FLIP_V:     flip_v_q     <= cfg_data[0];
				REG_WIDTH:      w_m1_q       <= size_m1(cfg_data[SIZE_W-1:0]);
				REG_HEIGHT:     h_m1_q       <= size_m1(cfg_data[SIZE_W-1:0]);
				REG_LP_TICKS:   lp_ticks_q   <= cfg_data;
				REG_LP_MOTION:  lp_motion_q  <= cfg_data;
				REG_TAP_MOTION: tap_motion_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			idx_s1 <= s_tuser[0];
			ev_s1  <= s_tdata[7:0];
			xl_s1  <= s_tdata[15:8];
			idy_s1 <= s_tdata[23:16];
			yl_s1  <= s_tdata[31:24];
		end
	end

	always_comb begin
		rx   = {ev_s1[3:0], xl_s1};
		ry   = {idy_s1[3:0], yl_s1};
		x_sw = swap_q ? ry : rx;
		y_sw = swap_q ? rx : ry;
		x_cl = (x_sw > w_m1_q) ? w_m1_q : x_sw;
		y_cl = (y_sw > h_m1_q) ? h_m1_q : y_sw;
		x_n  = flip_h_q ? (w_m1_q - x_cl) : x_cl;
		y_n  = flip_v_q ? (h_m1_q - y_cl) : y_cl;

		case (ev_s1[7:6])
			EV_PRESS:   kind = KIND_PRESS;
			EV_LIFT:    kind = KIND_LIFT;
			EV_CONTACT: kind = KIND_CONTACT;
			EV_NONE:    kind = KIND_NONE;
			default:    kind = KIND_NONE;
		endcase

		// out of range point index uses the last point
		p = (int'(idx_s1) < TOUCH_POINTS) ? PW'(idx_s1) : PW'(TOUCH_POINTS - 1);

		dx_n   = last_dx_q[p];
		dy_n   = last_dy_q[p];
		sdx_n  = sum_dx_q[p];
		sdy_n  = sum_dy_q[p];
		hold_n = hold_q[p];
		mark_n = mark_q[p];
		sdx_ext  = '0;
		sdy_ext  = '0;
		hold_inc = hold_q[p] + 16'd1;

		case (kind)
			KIND_PRESS: begin
				dx_n   = '0;
				dy_n   = '0;
				sdx_n  = '0;
				sdy_n  = '0;
				hold_n = '0;
				mark_n = 1'b0;
			end
			KIND_CONTACT: begin
				dx_n = {1'b0, x_n} - {1'b0, last_x_q[p]};
				dy_n = {1'b0, y_n} - {1'b0, last_y_q[p]};
				sdx_ext = {sum_dx_q[p][SUM_W-1], sum_dx_q[p]}
					+ {{(MOTION_W - DELTA_W){dx_n[DELTA_W-1]}}, dx_n};
				sdy_ext = {sum_dy_q[p][SUM_W-1], sum_dy_q[p]}
					+ {{(MOTION_W - DELTA_W){dy_n[DELTA_W-1]}}, dy_n};
				if (sdx_ext[MOTION_W-1] != sdx_ext[SUM_W-1])
					sdx_n = sdx_ext[MOTION_W-1] ? SUM_NEG_MAX : SUM_POS_MAX;
				else
					sdx_n = sdx_ext[SUM_W-1:0];
				if (sdy_ext[MOTION_W-1] != sdy_ext[SUM_W-1])
					sdy_n = sdy_ext[MOTION_W-1] ? SUM_NEG_MAX : SUM_POS_MAX;
				else
					sdy_n = sdy_ext[SUM_W-1:0];
				if (hold_q[p] != TICK_MAX)
					hold_n = hold_inc;
			end
			default: ;
		endcase

		motion_n = {1'b0, abs16(sdx_n)} + {1'b0, abs16(sdy_n)};

		// long press is checked only on the tick that reaches the limit
		if (kind == KIND_CONTACT && hold_q[p] != TICK_MAX && hold_inc == lp_ticks_q
			&& motion_n < {1'b0, lp_motion_q})
			mark_n = 1'b1;

		tap_n = motion_n < {1'b0, tap_motion_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOUCH_POINTS; i++) begin
				last_x_q[i]  <= '0;
				last_y_q[i]  <= '0;
				last_dx_q[i] <= '0;
				last_dy_q[i] <= '0;
				sum_dx_q[i]  <= '0;
				sum_dy_q[i]  <= '0;
				hold_q[i]    <= '0;
				mark_q[i]    <= 1'b0;
			end
		end else if (adv) begin
			last_x_q[p]  <= x_n;
			last_y_q[p]  <= y_n;
			last_dx_q[p] <= dx_n;
			last_dy_q[p] <= dy_n;
			sum_dx_q[p]  <= sdx_n;
			sum_dy_q[p]  <= sdy_n;
			hold_q[p]    <= hold_n;
			mark_q[p]    <= mark_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_data_q <= {{PAD_W{1'b0}}, tap_n, mark_n, dy_n, dx_n, y_n, x_n};
			m_user_q <= {kind, idx_s1};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule
